FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the allocator core; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property violated");
`define ASSERT_NOT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NOT(lbl, clk, rstn, prop)
`endif
`endif

FILE: hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, constants and helpers of the first-fit free list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned SumW         = 32 + $clog2(TableEntries);
  localparam int unsigned FieldCntW    = 7;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_LOST   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] region_addr;
    logic [31:0] region_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          alloc_addr;
    logic [32:0]          free_total;
    logic [FieldCntW-1:0] entries_used;
    logic [FieldCntW-1:0] entries_peak;
    logic [31:0]          lost_count;
    logic [31:0]          lost_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } region_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic load;
  } cell_ctrl_t;

  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    r = (|v[33:32]) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

  function automatic logic [FieldCntW-1:0] cnt_field(input logic [CntW-1:0] c);
    logic [CntW+FieldCntW-1:0] ext;
    ext = (CntW + FieldCntW)'(c);
    return ext[FieldCntW-1:0];
  endfunction

endpackage

FILE: hw/rtl/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit allocator over an address-sorted chain of free-region cells.
// ----------------------------------------------------------------------------
// Items are handled one at a time: the next item is accepted only after the
// previous one has committed and the core is idle again. Each item passes a
// scan step, in which every cell compares its region against the request and
// a prefix mask marks the first hit, a gather step to pick out the hit region
// and its left neighbor, a calc step for the merge and trim arithmetic, and a
// commit step in which the whole chain shifts or reloads at once while the
// result register is written. The commit step waits while the previous result
// is still held on the output. The free total is kept as a running sum, so it
// costs no pass over the table.
`include "assert_macros.svh"

module first_fit_free_list_allocator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffa_pkg::out_item_t out_item_o
);
  import ffa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_GATHER = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WR_CUR,
    OP_WR_PREV,
    OP_MERGE_BOTH,
    OP_REMOVE,
    OP_INSERT
  } op_e;

  state_e state_q, state_d;

  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  peak_q, peak_d;
  logic [31:0]      dropped_q, dropped_d;
  logic [31:0]      bytes_q, bytes_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             out_valid_q;

  in_item_t         item_q;
  logic [TableEntries-1:0] mask_q;
  region_t          cur_q, prev_q;
  logic             has_cur_q, has_prev_q;
  op_e              op_q, op_d;
  region_t          wr_q, wr_d;
  logic [32:0]      add_q, add_d;
  logic [32:0]      sub_q, sub_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      addr_q, addr_d;
  out_item_t        out_item_q, out_item_d;

  region_t          regions   [TableEntries];
  cell_ctrl_t       ctrl      [TableEntries];
  logic [TableEntries-1:0] valid_vec, fit_vec, above_vec, flag_vec, mask_d;
  logic [TableEntries-1:0] cur_oh, prev_oh;
  region_t          cur_sel, prev_sel;

  logic in_fire, out_free, commit_fire;
  logic is_alloc;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit_fire = (state_q == ST_COMMIT) && out_free;
  assign is_alloc    = (item_q.kind == KIND_ALLOC);

  // cell chain
  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    region_t left_w, right_w;

    assign valid_vec[g] = (CntW'(g) < used_q);

    if (g == 0) begin : g_first
      assign left_w     = wr_q;
      assign cur_oh[g]  = mask_q[g];
    end else begin : g_mid
      assign left_w     = regions[g-1];
      assign cur_oh[g]  = mask_q[g] & ~mask_q[g-1];
    end

    if (g == TableEntries - 1) begin : g_last
      assign right_w    = regions[g];
      assign prev_oh[g] = ~mask_q[g];
    end else begin : g_inner
      assign right_w    = regions[g+1];
      assign prev_oh[g] = ~mask_q[g] & mask_q[g+1];
    end

    assign flag_vec[g] = is_alloc ? fit_vec[g] : (above_vec[g] | ~valid_vec[g]);
    assign mask_d[g]   = |flag_vec[g:0];

    ffa_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[g]),
      .left_i     (left_w),
      .right_i    (right_w),
      .load_i     (wr_q),
      .valid_i    (valid_vec[g]),
      .req_addr_i (item_q.region_addr),
      .req_size_i (item_q.region_size),
      .region_o   (regions[g]),
      .fit_o      (fit_vec[g]),
      .above_o    (above_vec[g])
    );
  end

  // per-cell control for the commit cycle
  always_comb begin
    for (int k = 0; k < TableEntries; k++) begin
      ctrl[k] = '0;
      if (commit_fire) begin
        unique case (op_q)
          OP_WR_CUR:     ctrl[k].load = cur_oh[k];
          OP_WR_PREV:    ctrl[k].load = prev_oh[k];
          OP_MERGE_BOTH: begin
            ctrl[k].load       = prev_oh[k];
            ctrl[k].take_right = mask_q[k];
          end
          OP_REMOVE:     ctrl[k].take_right = mask_q[k];
          OP_INSERT: begin
            ctrl[k].load      = cur_oh[k];
            ctrl[k].take_left = mask_q[k] & ~cur_oh[k];
          end
          default:       ctrl[k] = '0;
        endcase
      end
    end
  end

  // pick out the hit region and its left neighbor
  always_comb begin
    cur_sel  = '0;
    prev_sel = '0;
    for (int k = 0; k < TableEntries; k++) begin
      cur_sel  = cur_sel  | (cur_oh[k]  ? regions[k] : '0);
      prev_sel = prev_sel | (prev_oh[k] ? regions[k] : '0);
    end
  end

  // merge, trim and insert decision
  always_comb begin
    logic [32:0] prev_end;
    logic [32:0] after;
    logic        merge_prev, merge_next;
    logic [33:0] len_prev;
    logic [33:0] len_next;

    prev_end   = {1'b0, prev_q.start} + {1'b0, prev_q.length};
    after      = {1'b0, item_q.region_addr} + {1'b0, item_q.region_size};
    merge_prev = has_prev_q && (prev_end == {1'b0, item_q.region_addr});
    merge_next = has_cur_q && (after == {1'b0, cur_q.start});
    len_prev   = {2'b00, prev_q.length} + {2'b00, item_q.region_size}
               + (merge_next ? {2'b00, cur_q.length} : 34'd0);
    len_next   = {2'b00, cur_q.length} + {2'b00, item_q.region_size};

    op_d     = OP_NONE;
    wr_d     = '0;
    add_d    = '0;
    sub_d    = '0;
    status_d = STATUS_OK;
    addr_d   = '0;

    unique case (item_q.kind)
      KIND_ALLOC: begin
        if (has_cur_q) begin
          addr_d       = cur_q.start;
          wr_d.start   = cur_q.start + item_q.region_size;
          wr_d.length  = cur_q.length - item_q.region_size;
          sub_d        = {1'b0, item_q.region_size};
          op_d         = (cur_q.length == item_q.region_size) ? OP_REMOVE : OP_WR_CUR;
        end else begin
          status_d = STATUS_NO_FIT;
        end
      end
      KIND_FREE: begin
        if (merge_prev) begin
          wr_d.start  = prev_q.start;
          wr_d.length = sat32(len_prev);
          add_d       = {1'b0, sat32(len_prev)};
          sub_d       = {1'b0, prev_q.length}
                      + (merge_next ? {1'b0, cur_q.length} : 33'd0);
          op_d        = merge_next ? OP_MERGE_BOTH : OP_WR_PREV;
        end else if (merge_next) begin
          wr_d.start  = item_q.region_addr;
          wr_d.length = sat32(len_next);
          add_d       = {1'b0, sat32(len_next)};
          sub_d       = {1'b0, cur_q.length};
          op_d        = OP_WR_CUR;
        end else if (used_q < CntW'(TableEntries)) begin
          wr_d.start  = item_q.region_addr;
          wr_d.length = item_q.region_size;
          add_d       = {1'b0, item_q.region_size};
          op_d        = OP_INSERT;
        end else begin
          status_d = STATUS_LOST;
        end
      end
      default: begin
        op_d = OP_NONE;
      end
    endcase
  end

  // statistics and result
  always_comb begin
    logic [32:0] bytes_sum;

    used_d    = used_q;
    peak_d    = peak_q;
    dropped_d = dropped_q;
    bytes_d   = bytes_q;
    sum_d     = sum_q + SumW'(add_q) - SumW'(sub_q);
    bytes_sum = {1'b0, bytes_q} + {1'b0, item_q.region_size};

    if (item_q.kind == KIND_CLEAR) begin
      used_d    = '0;
      peak_d    = '0;
      dropped_d = '0;
      bytes_d   = '0;
      sum_d     = '0;
    end else begin
      unique case (op_q)
        OP_MERGE_BOTH, OP_REMOVE: used_d = used_q - CntW'(1);
        OP_INSERT:                used_d = used_q + CntW'(1);
        default:                  used_d = used_q;
      endcase
      if (used_d > peak_q) begin
        peak_d = used_d;
      end
      if (status_q == STATUS_LOST) begin
        if (dropped_q != 32'hFFFF_FFFF) begin
          dropped_d = dropped_q + 32'd1;
        end
        bytes_d = sat32({1'b0, bytes_sum});
      end
    end

    out_item_d.status       = status_q;
    out_item_d.alloc_addr   = addr_q;
    out_item_d.free_total   = (sum_d > SumW'(34'h1_FFFF_FFFF)) ? 33'h1_FFFF_FFFF
                                                                : sum_d[32:0];
    out_item_d.entries_used = cnt_field(used_d);
    out_item_d.entries_peak = cnt_field(peak_d);
    out_item_d.lost_count   = dropped_d;
    out_item_d.lost_bytes   = bytes_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_SCAN;
      ST_SCAN:   state_d = ST_GATHER;
      ST_GATHER: state_d = ST_CALC;
      ST_CALC:   state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      peak_q      <= '0;
      dropped_q   <= '0;
      bytes_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_fire) begin
        used_q      <= used_d;
        peak_q      <= peak_d;
        dropped_q   <= dropped_d;
        bytes_q     <= bytes_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_SCAN) begin
      mask_q <= mask_d;
    end
    if (state_q == ST_GATHER) begin
      cur_q      <= cur_sel;
      prev_q     <= prev_sel;
      has_cur_q  <= |(cur_oh & valid_vec);
      has_prev_q <= ~mask_q[0];
    end
    if (state_q == ST_CALC) begin
      op_q     <= op_d;
      wr_q     <= wr_d;
      add_q    <= add_d;
      sub_q    <= sub_d;
      status_q <= status_d;
      addr_q   <= addr_d;
    end
    if (commit_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_PROP(a_peak_covers_used, clk_i, rst_ni, peak_q >= used_q)
  `ASSERT_PROP(a_commit_posts, clk_i, rst_ni, commit_fire |=> out_valid_q && state_q == ST_IDLE)
  `ASSERT_PROP(a_lost_when_full, clk_i, rst_ni, out_valid_q && out_item_q.status == STATUS_LOST |-> used_q == CntW'(TableEntries))
  `ASSERT_NOT(a_no_accept_busy, clk_i, rst_ni, in_fire && state_q != ST_IDLE)

endmodule

FILE: hw/rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One table slot: holds a free region, compares it against the request and
// loads from its left or right neighbor or from the broadcast write data.
// ----------------------------------------------------------------------------
module ffa_cell (
  input  logic                clk_i,
  input  ffa_pkg::cell_ctrl_t ctrl_i,
  input  ffa_pkg::region_t    left_i,
  input  ffa_pkg::region_t    right_i,
  input  ffa_pkg::region_t    load_i,
  input  logic                valid_i,
  input  logic [31:0]         req_addr_i,
  input  logic [31:0]         req_size_i,
  output ffa_pkg::region_t    region_o,
  output logic                fit_o,
  output logic                above_o
);
  import ffa_pkg::*;

  region_t region_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.take_left) begin
      region_q <= left_i;
    end else if (ctrl_i.take_right) begin
      region_q <= right_i;
    end else if (ctrl_i.load) begin
      region_q <= load_i;
    end else begin
      region_q <= region_q;
    end
  end

  assign region_o = region_q;
  assign fit_o    = valid_i && (region_q.length >= req_size_i);
  assign above_o  = valid_i && (region_q.start > req_addr_i);

endmodule
